### hw/rtl/adcvm_pkg.sv
// ----------------------------------------------------------------------------
// adcvm_pkg: shared types and constants for the averaging voltmeter display
// Holds the item structs, command codes, sizing constants and the
// seven-segment glyph decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package adcvm_pkg;

   // Number of samples averaged for one shown value (1..16).
   localparam int SAMPLES = 8;

   // Scaled sample range: 0..ScaledMax tenths of a volt.
   localparam int ScaledMax   = 33;
   localparam int ScaledWidth = $clog2(ScaledMax + 1);
   localparam int SampleWidth = 10;
   localparam int ScaleMul    = 33;
   localparam int ScaleRound  = 511;
   localparam int ScaleDiv    = 1023;
   localparam int ProdWidth   = 16;

   // The running sum reaches SAMPLES * ScaledMax just before it is averaged.
   localparam int SumWidth   = $clog2(SAMPLES * ScaledMax + 1);
   localparam int CountWidth = $clog2(SAMPLES + 1);

   localparam logic CMD_SAMPLE = 1'b0;
   localparam logic CMD_TICK   = 1'b1;

   typedef struct packed {
      logic                   command;
      logic [SampleWidth-1:0] sample;
   } req_type;

   typedef struct packed {
      logic [6:0] segments;
      logic       high_digit_on;
      logic [5:0] shown_value;
   } rsp_type;

   // Seven-segment pattern, bit 0 = segment a through bit 6 = segment g.
   function automatic logic [6:0] seg_code(input logic [3:0] nib);
      logic [6:0] code;
      unique case (nib)
         4'h0: code = 7'h3F;
         4'h1: code = 7'h06;
         4'h2: code = 7'h5B;
         4'h3: code = 7'h4F;
         4'h4: code = 7'h66;
         4'h5: code = 7'h6D;
         4'h6: code = 7'h7D;
         4'h7: code = 7'h07;
         4'h8: code = 7'h7F;
         4'h9: code = 7'h6F;
         4'hA: code = 7'h77;
         4'hB: code = 7'h7C;
         4'hC: code = 7'h39;
         4'hD: code = 7'h5E;
         4'hE: code = 7'h79;
         default: code = 7'h71;
      endcase
      return code;
   endfunction

endpackage

`default_nettype wire

### hw/rtl/adc_average_voltmeter_display_top.sv
// A refresh tick item passes from the input register to the result register.
// Throughput: one item per cycle; a tick and all items behind it wait while a result is unread.
// The input register feeds one short pass (constant scale, accumulate,
// average, BCD split, digit decode) into the state and result registers.
// Samples give no result. Reset (synchronous, active high) clears the sum,
// count, shown value and digit phase, and empties both registers.
// ----------------------------------------------------------------------------
// adc_average_voltmeter_display_top: averaging voltmeter with 2-digit display
// Averages scaled converter samples in tenths of a volt and, on each
// refresh tick, returns the seven-segment pattern of the alternate digit.
// ----------------------------------------------------------------------------
`default_nettype none

module adc_average_voltmeter_display_top (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_ready,
   input  wire adcvm_pkg::req_type req_data,
   output logic                   rsp_valid,
   input  wire logic              rsp_ready,
   output adcvm_pkg::rsp_type     rsp_data
);

   // Input register stage.
   logic               in_valid_ff;
   adcvm_pkg::req_type in_data_ff;

   // Block state.
   logic [adcvm_pkg::SumWidth-1:0]   sum_ff, sum_in;
   logic [adcvm_pkg::CountWidth-1:0] count_ff, count_in;
   logic [1:0]                       tens_ff, tens_in;
   logic [3:0]                       ones_ff, ones_in;
   logic                             phase_ff;

   // Result register stage.
   logic               rsp_valid_ff;
   adcvm_pkg::rsp_type rsp_data_ff, rsp_data_in;

   logic is_tick;
   logic advance;
   logic fire_tick;
   logic fire_sample;

   // A registered tick may only move on once the result register has room;
   // samples produce nothing and always move on.
   assign is_tick     = in_data_ff.command == adcvm_pkg::CMD_TICK;
   assign advance     = in_valid_ff && !(is_tick && rsp_valid_ff && !rsp_ready);
   assign fire_tick   = advance && is_tick;
   assign fire_sample = advance && !is_tick;
   assign req_ready   = !in_valid_ff || advance;

   // Scaling: x = s*33 + 511, then x / 1023. Since x/1024 is either the
   // quotient or one less, one remainder compare finishes the division.
   logic [adcvm_pkg::ProdWidth-1:0]   prod;
   logic [adcvm_pkg::ProdWidth-1:0]   q0_times_div;
   logic [adcvm_pkg::ProdWidth-1:0]   rem0;
   logic [adcvm_pkg::ScaledWidth-1:0] q0;
   logic [adcvm_pkg::ScaledWidth-1:0] scaled;

   always_comb begin
      prod = (adcvm_pkg::ProdWidth'(in_data_ff.sample) << 5)
           + adcvm_pkg::ProdWidth'(in_data_ff.sample)
           + adcvm_pkg::ProdWidth'(adcvm_pkg::ScaleRound);
      q0 = adcvm_pkg::ScaledWidth'(prod >> 10);
      q0_times_div = (adcvm_pkg::ProdWidth'(q0) << 10) - adcvm_pkg::ProdWidth'(q0);
      rem0 = prod - q0_times_div;
      scaled = q0 + adcvm_pkg::ScaledWidth'(rem0 >= adcvm_pkg::ProdWidth'(adcvm_pkg::ScaleDiv));
   end

   // Accumulate, and on the last sample of a group average and split into
   // BCD. The average never exceeds 33, so the tens digit is found by
   // three compares.
   logic [adcvm_pkg::SumWidth-1:0] sum_next;
   logic [5:0]                     avg;

   always_comb begin
      sum_next = sum_ff + adcvm_pkg::SumWidth'(scaled);
      avg      = 6'(sum_next / adcvm_pkg::SAMPLES);
      sum_in   = sum_ff;
      count_in = count_ff;
      tens_in  = tens_ff;
      ones_in  = ones_ff;
      if (fire_sample) begin
         if (count_ff == adcvm_pkg::CountWidth'(adcvm_pkg::SAMPLES - 1)) begin
            sum_in   = '0;
            count_in = '0;
            if (avg >= 6'd30) begin
               tens_in = 2'd3;
               ones_in = 4'(avg - 6'd30);
            end else if (avg >= 6'd20) begin
               tens_in = 2'd2;
               ones_in = 4'(avg - 6'd20);
            end else if (avg >= 6'd10) begin
               tens_in = 2'd1;
               ones_in = 4'(avg - 6'd10);
            end else begin
               tens_in = 2'd0;
               ones_in = 4'(avg);
            end
         end else begin
            sum_in   = sum_next;
            count_in = count_ff + 1'b1;
         end
      end
   end

   // The display result: the low digit when the phase is clear, else high.
   always_comb begin
      rsp_data_in.segments      = adcvm_pkg::seg_code(phase_ff ? {2'b00, tens_ff} : ones_ff);
      rsp_data_in.high_digit_on = phase_ff;
      rsp_data_in.shown_value   = {tens_ff, ones_ff};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         sum_ff       <= '0;
         count_ff     <= '0;
         tens_ff      <= '0;
         ones_ff      <= '0;
         phase_ff     <= 1'b0;
      end else begin
         if (req_ready) begin
            in_valid_ff <= req_valid;
         end
         if (fire_tick) begin
            rsp_valid_ff <= 1'b1;
            phase_ff     <= !phase_ff;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         sum_ff   <= sum_in;
         count_ff <= count_in;
         tens_ff  <= tens_in;
         ones_ff  <= ones_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_ready && req_valid) begin
         in_data_ff <= req_data;
      end
      if (fire_tick) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

`ifndef SYNTHESIS
   // The sample count wraps before it reaches the group size.
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff < adcvm_pkg::CountWidth'(adcvm_pkg::SAMPLES))
      else $error("sample count out of range");

   // The stored sum never holds a complete group.
   a_sum_range: assert property (@(posedge clock) disable iff (reset)
      sum_ff <= adcvm_pkg::SumWidth'((adcvm_pkg::SAMPLES - 1) * adcvm_pkg::ScaledMax))
      else $error("running sum out of range");

   // The shown value is always a decimal digit pair.
   a_bcd_digit: assert property (@(posedge clock) disable iff (reset)
      ones_ff <= 4'd9)
      else $error("ones digit not decimal");

   // A tick held back by a full result register stays in the input register.
   a_tick_held: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && is_tick && rsp_valid_ff && !rsp_ready |=> in_valid_ff && is_tick)
      else $error("stalled tick lost");

   // Every processed tick flips the digit phase.
   a_phase_flip: assert property (@(posedge clock) disable iff (reset)
      fire_tick |=> phase_ff != $past(phase_ff))
      else $error("digit phase did not alternate");
`endif

endmodule

`default_nettype wire

### dv/adcvm_display_checker.sv
// ----------------------------------------------------------------------------
// adcvm_display_checker: result checker for the averaging voltmeter display
// Watches both channels, predicts each display result from the accepted
// items and compares the results field by field in arrival order.
// ----------------------------------------------------------------------------
`default_nettype none

module adcvm_display_checker (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   input  wire logic               req_ready,
   input  wire adcvm_pkg::req_type req_data,
   input  wire logic               rsp_valid,
   input  wire logic               rsp_ready,
   input  wire adcvm_pkg::rsp_type rsp_data,
   output int                      mismatch_count,
   output int                      displays_pending,
   output int                      displays_checked
);

   localparam int SCALE_NUM   = 33;
   localparam int SCALE_ROUND = 511;
   localparam int SCALE_DEN   = 1023;

   // Glyphs for nibbles 15 down to 0, bit 0 = segment a.
   localparam logic [16*7-1:0] GLYPHS = {
      7'h71, 7'h79, 7'h5E, 7'h39, 7'h7C, 7'h77, 7'h6F, 7'h7F,
      7'h07, 7'h7D, 7'h6D, 7'h66, 7'h4F, 7'h5B, 7'h06, 7'h3F
   };

   logic [adcvm_pkg::SumWidth-1:0]   tenths_sum;
   logic [adcvm_pkg::CountWidth-1:0] samples_taken;
   logic [7:0]                       shown_bcd;
   logic                             showing_high;

   adcvm_pkg::rsp_type displays_due[$];

   task automatic report_mismatch(input string what, input int got, input int want);
      mismatch_count++;
      $display("ERROR: display result %0d, %s: got 0x%0h, expected 0x%0h",
               displays_checked, what, got, want);
   endtask

   always @(posedge clock) begin : watch
      adcvm_pkg::rsp_type want;
      int                 scaled;
      int                 average;
      logic [3:0]         digit;
      if (reset) begin
         tenths_sum       = '0;
         samples_taken    = '0;
         shown_bcd        = '0;
         showing_high     = 1'b0;
         mismatch_count   = 0;
         displays_checked = 0;
         displays_due.delete();
      end else begin
         if (req_valid && req_ready) begin
            if (req_data.command == adcvm_pkg::CMD_SAMPLE) begin
               scaled = (int'(req_data.sample) * SCALE_NUM + SCALE_ROUND) / SCALE_DEN;
               tenths_sum    = tenths_sum + adcvm_pkg::SumWidth'(scaled);
               samples_taken = samples_taken + 1'b1;
               if (samples_taken >= adcvm_pkg::SAMPLES) begin
                  average       = int'(tenths_sum) / adcvm_pkg::SAMPLES;
                  shown_bcd     = {4'(average / 10), 4'(average % 10)};
                  tenths_sum    = '0;
                  samples_taken = '0;
               end
            end else begin
               digit              = showing_high ? shown_bcd[7:4] : shown_bcd[3:0];
               want.segments      = GLYPHS[digit*7 +: 7];
               want.high_digit_on = showing_high;
               want.shown_value   = shown_bcd[5:0];
               displays_due.push_back(want);
               showing_high = ~showing_high;
            end
         end
         if (rsp_valid && rsp_ready) begin
            if (displays_due.size() == 0) begin
               report_mismatch("result with none expected", int'(rsp_data), 0);
            end else begin
               want = displays_due.pop_front();
               if (rsp_data.segments !== want.segments)
                  report_mismatch("segments", int'(rsp_data.segments),
                                  int'(want.segments));
               if (rsp_data.high_digit_on !== want.high_digit_on)
                  report_mismatch("high_digit_on", int'(rsp_data.high_digit_on),
                                  int'(want.high_digit_on));
               if (rsp_data.shown_value !== want.shown_value)
                  report_mismatch("shown_value", int'(rsp_data.shown_value),
                                  int'(want.shown_value));
            end
            displays_checked++;
         end
      end
      displays_pending = displays_due.size();
   end

endmodule

`default_nettype wire

### dv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: testbench for the averaging voltmeter display
// Drives converter samples and refresh ticks under changing flow control;
// a checker beside the block predicts and compares every display result.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;

   // Eight-unit clock period; the run is cut off if it ever gets this long.
   localparam int CYCLE_LIMIT  = 400000;
   localparam int ITEMS_PER_LEG = 450;
   localparam int TAIL_CYCLES  = 8;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic               req_valid = 1'b0;
   logic               req_ready;
   adcvm_pkg::req_type req_data  = '0;
   logic               rsp_valid;
   logic               rsp_ready = 1'b0;
   adcvm_pkg::rsp_type rsp_data;

   int mismatch_count;
   int displays_pending;
   int displays_checked;

   // Percent chance that the sender, or the receiver, sits out a cycle.
   int tx_idle_pct = 0;
   int rx_idle_pct = 0;

   int cycles      = 0;
   int samples_fed = 0;
   int ticks_fed   = 0;

   adc_average_voltmeter_display_top DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   adcvm_display_checker display_checker (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_data         (req_data),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_data         (rsp_data),
      .mismatch_count   (mismatch_count),
      .displays_pending (displays_pending),
      .displays_checked (displays_checked)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Watchdog. A hung handshake or a lost result ends the run here as a failure.
   always @(posedge clock) begin
      cycles++;
      if (cycles >= CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles with %0d results outstanding",
                  cycles, displays_pending);
         $display("Mismatches found");
         $finish;
      end
   end

   // The receiver draws its ready afresh every cycle, so stalls land on every
   // phase of the result pipeline, including the cycle a result first shows.
   always @(negedge clock) begin
      rsp_ready <= ($urandom_range(0, 99) >= rx_idle_pct);
   end

   // Offers one item. The sender may first sit idle as tx_idle_pct draws; once
   // valid is raised it is held with a steady payload until the item is
   // accepted. Valid is left high afterwards, so back-to-back items need only
   // a payload change at the next falling edge and never a drop and re-raise
   // of valid within one time step.
   task automatic send_item(input logic command, input logic [9:0] value);
      while ($urandom_range(0, 99) < tx_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= '{command: command, sample: value};
      do @(posedge clock); while (!req_ready);
      @(negedge clock);
      if (command == adcvm_pkg::CMD_SAMPLE)
         samples_fed++;
      else
         ticks_fed++;
   endtask

   initial begin : stimulus
      int level;
      int jitter;
      int value;
      int leg;
      int n;

      // Synchronous reset, released at a falling edge.
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed part, with no idling. Right after reset the shown value is
      // zero and the low digit comes first; the second tick carries an
      // all-ones sample field, which the block must ignore.
      send_item(adcvm_pkg::CMD_TICK, 10'h000);
      send_item(adcvm_pkg::CMD_TICK, 10'h3FF);

      // A full window of full-scale samples gives the top reading, 3.3 V.
      repeat (adcvm_pkg::SAMPLES) send_item(adcvm_pkg::CMD_SAMPLE, 10'h3FF);
      send_item(adcvm_pkg::CMD_TICK, 10'h155);
      send_item(adcvm_pkg::CMD_TICK, 10'h2AA);

      // Samples on both sides of the rounding steps: 15 still scales to zero
      // while 16 gives one tenth, and 511 and 512 straddle the middle of the
      // range. Together with full scale and zero the window averages to 0.8 V.
      send_item(adcvm_pkg::CMD_SAMPLE, 10'd15);
      send_item(adcvm_pkg::CMD_SAMPLE, 10'd16);
      send_item(adcvm_pkg::CMD_SAMPLE, 10'd15);
      send_item(adcvm_pkg::CMD_SAMPLE, 10'd16);
      send_item(adcvm_pkg::CMD_SAMPLE, 10'd511);
      send_item(adcvm_pkg::CMD_SAMPLE, 10'd512);
      send_item(adcvm_pkg::CMD_SAMPLE, 10'd1023);
      send_item(adcvm_pkg::CMD_SAMPLE, 10'd0);
      send_item(adcvm_pkg::CMD_TICK, 10'h000);
      send_item(adcvm_pkg::CMD_TICK, 10'h000);

      // Random part in three legs: a slow receiver, then a slow sender, then
      // full speed on both sides. Samples mostly cluster around a level that
      // drifts now and then, so the averages sweep the whole 0.0 V to 3.3 V
      // range instead of settling near mid-scale; one sample in ten is
      // anywhere in the range. About two items in five are refresh ticks.
      level = $urandom_range(0, 1023);
      for (leg = 0; leg < 3; leg++) begin
         case (leg)
            0: begin
               tx_idle_pct = 29;
               rx_idle_pct = 87;
            end
            1: begin
               tx_idle_pct = 87;
               rx_idle_pct = 29;
            end
            default: begin
               tx_idle_pct = 0;
               rx_idle_pct = 0;
            end
         endcase
         for (n = 0; n < ITEMS_PER_LEG; n++) begin
            if ($urandom_range(0, 99) < 40) begin
               send_item(adcvm_pkg::CMD_TICK, 10'($urandom));
            end else begin
               if ($urandom_range(0, 7) == 0)
                  level = $urandom_range(0, 1023);
               if ($urandom_range(0, 9) == 0) begin
                  value = $urandom_range(0, 1023);
               end else begin
                  jitter = $urandom_range(0, 64);
                  value  = level + jitter - 32;
                  if (value < 0)
                     value = 0;
                  if (value > 1023)
                     value = 1023;
               end
               send_item(adcvm_pkg::CMD_SAMPLE, 10'(value));
            end
         end
      end
      req_valid <= 1'b0;

      // Drain: wait for every predicted result, then through the TAIL_CYCLES tail so a
      // stray extra result would still be caught by the checker.
      while (displays_pending != 0) @(negedge clock);
      repeat (TAIL_CYCLES) @(negedge clock);

      $display("Fed %0d converter samples and %0d refresh ticks in %0d cycles;",
               samples_fed, ticks_fed, cycles);
      $display("checked %0d display results under three flow-control mixes.",
               displays_checked);
      if (mismatch_count == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule

`default_nettype wire
